// ===== hdl/calendar_timestamp_stepper_assert.svh =====
// Assertion macros for the calendar timestamp stepper.
// Included by files that check their own logic; needs no package.
`ifndef CALENDAR_TIMESTAMP_STEPPER_ASSERT_SVH
`define CALENDAR_TIMESTAMP_STEPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar_timestamp_stepper: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar_timestamp_stepper: assertion failed");

`endif

// ===== hdl/cts_pkg.sv =====
// Types, constants and calendar helpers for the calendar timestamp stepper.
// No dependencies; used by every module of the block.
`default_nettype none

package cts_pkg;

  localparam logic [13:0] YEAR_MIN      = 14'd1900;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [6:0]  CENT_RESET    = 7'd19;
  localparam logic [6:0]  YY_LAST       = 7'd99;
  localparam logic [3:0]  MONTH_FIRST   = 4'd1;
  localparam logic [3:0]  MONTH_LAST    = 4'd12;
  localparam logic [4:0]  DAY_FIRST     = 5'd1;
  localparam logic [4:0]  HOUR_LAST     = 5'd23;
  localparam logic [5:0]  MINSEC_LAST   = 6'd59;
  localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN_W = 17'd60;
  localparam logic [13:0] YEARS_PER_CENT = 14'd100;

  // Reciprocals for the step and start-year split: q = (x * RECIP) >> SHIFT.
  // Exact for step up to 86400, remainder below 3600 and year up to 9999.
  localparam logic [15:0] HOUR_RECIP = 16'd37283;
  localparam int unsigned HOUR_SHIFT = 27;
  localparam logic [14:0] MIN_RECIP  = 15'd17477;
  localparam int unsigned MIN_SHIFT  = 20;
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int unsigned CENT_SHIFT = 19;

  localparam logic [4:0] DAYS_31 = 5'd31;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_28 = 5'd28;

  typedef enum logic [2:0] {
    REG_START_YEAR   = 3'd0,
    REG_START_MONTH  = 3'd1,
    REG_START_DAY    = 3'd2,
    REG_START_HOUR   = 3'd3,
    REG_START_MINUTE = 3'd4,
    REG_START_SECOND = 3'd5,
    REG_STEP_SECONDS = 3'd6,
    REG_SENSOR_COUNT = 3'd7
  } reg_idx_e;

  // Step / start-year split sequencer.
  typedef enum logic [4:0] {
    SPLIT_IDLE  = 5'b00001,
    SPLIT_QUOT  = 5'b00010,  // hour and century quotients
    SPLIT_REM   = 5'b00100,  // take them back out
    SPLIT_MQUOT = 5'b01000,  // minute quotient
    SPLIT_MREM  = 5'b10000   // seconds remainder
  } split_state_e;

  // Date and time; year is also carried split into century and year of century.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  cent;
    logic [6:0]  yy;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    stamp_t      start;     // already saturated
    logic [4:0]  step_h;
    logic [5:0]  step_m;
    logic [5:0]  step_s;
    logic [6:0]  sensor_n;  // 1..MAX_SENSORS
    logic        busy;      // split running, values not settled
  } cfg_t;

  typedef struct packed {
    logic [6:0] sensor_id;
    logic [6:0] count;
  } emit_stat_t;

  function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yy);
    logic res;
    if (yy == 7'd0) res = (cent[1:0] == 2'd0);
    else            res = (yy[1:0] == 2'd0);
    return res;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] res;
    unique case (month)
      4'd2:                      res = leap ? DAYS_29 : DAYS_28;
      4'd4, 4'd6, 4'd9, 4'd11:   res = DAYS_30;
      default:                   res = DAYS_31;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/calendar_timestamp_stepper.sv =====
// Top level of the calendar timestamp stepper: register file, time core, emitter.
// Depends on cts_pkg, cts_cfg_regs, cts_time_core, cts_emitter and the assert header.
//
//  Channel   Dir   Handshake                  Content
//  s_axis    in    tvalid/tready              tdata[0] advance (0 load start, 1 add step)
//  m_axis    out   tvalid/tready, tlast       tdata: id, y, mo, d, h, mi, s; tlast on final
//  apb       in    psel/penable/pwrite/pready 8 registers at byte address 4*i, 32-bit data
//
//  Each item updates the time in the cycle it is transferred in and then yields
//  sensor_count records (1..MAX_SENSORS), one per cycle while m_axis_tready is
//  high, from the result register. The next item is taken in the cycle the final
//  record of the previous one leaves. A write to start_year or step_seconds
//  starts a split into h/m/s and century/year; s_axis_tready is low during it.
//  Reset is asynchronous; no clearing pass. m_axis stalls hold the record in place.
`default_nettype none

module calendar_timestamp_stepper #(
  parameter int unsigned MAX_SENSORS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] advance, [7:1] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [6:0] sensor_id, [20:7] out_year, [24:21] out_month,
                                      // [29:25] out_day, [34:30] out_hour,
                                      // [40:35] out_minute, [46:41] out_second, [47] zero
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cts_pkg::cfg_t       cfg;
  cts_pkg::stamp_t     next_stamp;
  cts_pkg::emit_stat_t emit_stat;
  logic                emit_free;
  logic                accept;

  // assertion helpers
  logic                rec_mid_xfer;
  logic [6:0]          rec_id;
  logic                tod_ok;

  // Input is gated only by the result register and the config split.
  assign s_axis_tready = emit_free && !cfg.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cts_cfg_regs #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cts_time_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .advance_i (s_axis_tdata[0]),
    .cfg_i     (cfg),
    .next_o    (next_stamp)
  );

  cts_emitter u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .stamp_i       (next_stamp),
    .count_i       (cfg.sensor_n),
    .free_o        (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .stat_o        (emit_stat)
  );

  assign rec_mid_xfer = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign rec_id       = emit_stat.sensor_id;
  assign tod_ok       = (m_axis_tdata[34:30] <= cts_pkg::HOUR_LAST) &&
                        (m_axis_tdata[40:35] <= cts_pkg::MINSEC_LAST) &&
                        (m_axis_tdata[46:41] <= cts_pkg::MINSEC_LAST);

`include "calendar_timestamp_stepper_assert.svh"

  // no transfer while the step/year split is settling
`CTS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, cfg.busy, !s_axis_tready)
  // final record carries the id equal to the record count
`CTS_ASSERT_IMP(a_last_id, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, rec_id == emit_stat.count)
  // a non-final transfer is followed by the next id
`CTS_ASSERT_NXT(a_id_step, clk_i, rst_ni, rec_mid_xfer, m_axis_tvalid && (rec_id == $past(rec_id) + 7'd1))
  // time of day always in range
`CTS_ASSERT_IMP(a_tod_range, clk_i, rst_ni, m_axis_tvalid, tod_ok)

endmodule

`default_nettype wire

// ===== hdl/cts_cfg_regs.sv =====
// APB register file of the calendar timestamp stepper, with the sequencer that
// splits step and start year into h/m/s and century/year. Depends on cts_pkg.
`default_nettype none

module cts_cfg_regs #(
  parameter int unsigned MAX_SENSORS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output cts_pkg::cfg_t  cfg_o
);

  logic [13:0] year_raw_q;
  logic [3:0]  month_raw_q;
  logic [4:0]  day_raw_q;
  logic [4:0]  hour_raw_q;
  logic [5:0]  min_raw_q;
  logic [5:0]  sec_raw_q;
  logic [16:0] step_raw_q;
  logic [6:0]  count_raw_q;

  logic [13:0] year_clamp_d, year_clamp_q;
  logic [16:0] step_clamp_d, step_clamp_q;
  logic [6:0]  count_clamp_d, count_clamp_q;
  logic [6:0]  max_n;

  cts_pkg::split_state_e split_q;
  logic                  busy;
  logic [13:0] yr_rem_q;
  logic [6:0]  cent_q;
  logic [16:0] st_rem_q;
  logic [4:0]  step_h_q;
  logic [5:0]  step_m_q;

  logic               wr_en, wr_year, wr_step;
  cts_pkg::reg_idx_e  idx;
  logic [32:0]        hour_prod;
  logic [26:0]        cent_prod;
  logic [26:0]        min_prod;
  logic [4:0]         hour_quo;
  logic [6:0]         cent_quo;
  logic [5:0]         min_quo;

  logic [3:0] mon_c;
  logic [4:0] dim;

  assign pready  = 1'b1;
  assign idx     = cts_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign wr_year = wr_en && (idx == cts_pkg::REG_START_YEAR);
  assign wr_step = wr_en && (idx == cts_pkg::REG_STEP_SECONDS);
  assign max_n   = 7'(MAX_SENSORS);
  assign busy    = (split_q != cts_pkg::SPLIT_IDLE);

  always_comb begin
    if (pwdata[13:0] < cts_pkg::YEAR_MIN)      year_clamp_d = cts_pkg::YEAR_MIN;
    else if (pwdata[13:0] > cts_pkg::YEAR_MAX) year_clamp_d = cts_pkg::YEAR_MAX;
    else                                       year_clamp_d = pwdata[13:0];
    if (pwdata[16:0] > cts_pkg::SEC_PER_DAY) step_clamp_d = cts_pkg::SEC_PER_DAY;
    else                                     step_clamp_d = pwdata[16:0];
    if (pwdata[6:0] == 7'd0)     count_clamp_d = 7'd1;
    else if (pwdata[6:0] > max_n) count_clamp_d = max_n;
    else                          count_clamp_d = pwdata[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_raw_q    <= 14'd2022;
      month_raw_q   <= 4'd1;
      day_raw_q     <= 5'd1;
      hour_raw_q    <= 5'd0;
      min_raw_q     <= 6'd0;
      sec_raw_q     <= 6'd0;
      step_raw_q    <= 17'd30;
      count_raw_q   <= 7'd1;
      year_clamp_q  <= 14'd2022;
      step_clamp_q  <= 17'd30;
      count_clamp_q <= 7'd1;
    end else if (wr_en) begin
      unique case (idx)
        cts_pkg::REG_START_YEAR: begin
          year_raw_q   <= pwdata[13:0];
          year_clamp_q <= year_clamp_d;
        end
        cts_pkg::REG_START_MONTH:  month_raw_q <= pwdata[3:0];
        cts_pkg::REG_START_DAY:    day_raw_q   <= pwdata[4:0];
        cts_pkg::REG_START_HOUR:   hour_raw_q  <= pwdata[4:0];
        cts_pkg::REG_START_MINUTE: min_raw_q   <= pwdata[5:0];
        cts_pkg::REG_START_SECOND: sec_raw_q   <= pwdata[5:0];
        cts_pkg::REG_STEP_SECONDS: begin
          step_raw_q   <= pwdata[16:0];
          step_clamp_q <= step_clamp_d;
        end
        cts_pkg::REG_SENSOR_COUNT: begin
          count_raw_q   <= pwdata[6:0];
          count_clamp_q <= count_clamp_d;
        end
        default: ;
      endcase
    end
  end

  // Division by fixed constants through reciprocal multiplication.
  always_comb begin
    hour_prod = 33'(st_rem_q) * 33'(cts_pkg::HOUR_RECIP);
    cent_prod = 27'(yr_rem_q) * 27'(cts_pkg::CENT_RECIP);
    min_prod  = 27'(st_rem_q[11:0]) * 27'(cts_pkg::MIN_RECIP);
    hour_quo  = 5'(hour_prod >> cts_pkg::HOUR_SHIFT);
    cent_quo  = 7'(cent_prod >> cts_pkg::CENT_SHIFT);
    min_quo   = 6'(min_prod >> cts_pkg::MIN_SHIFT);
  end

  // Four steps: hour/century quotient, remainder, minute quotient, seconds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q  <= cts_pkg::SPLIT_IDLE;
      yr_rem_q <= 14'd22;
      cent_q   <= 7'd20;
      st_rem_q <= 17'd30;
      step_h_q <= 5'd0;
      step_m_q <= 6'd0;
    end else if (wr_year || wr_step) begin
      split_q  <= cts_pkg::SPLIT_QUOT;
      yr_rem_q <= wr_year ? year_clamp_d : year_clamp_q;
      st_rem_q <= wr_step ? step_clamp_d : step_clamp_q;
    end else begin
      unique case (split_q)
        cts_pkg::SPLIT_QUOT: begin
          step_h_q <= hour_quo;
          cent_q   <= cent_quo;
          split_q  <= cts_pkg::SPLIT_REM;
        end
        cts_pkg::SPLIT_REM: begin
          st_rem_q <= st_rem_q - 17'(step_h_q) * cts_pkg::SEC_PER_HOUR;
          yr_rem_q <= yr_rem_q - 14'(cent_q) * cts_pkg::YEARS_PER_CENT;
          split_q  <= cts_pkg::SPLIT_MQUOT;
        end
        cts_pkg::SPLIT_MQUOT: begin
          step_m_q <= min_quo;
          split_q  <= cts_pkg::SPLIT_MREM;
        end
        cts_pkg::SPLIT_MREM: begin
          st_rem_q <= st_rem_q - 17'(step_m_q) * cts_pkg::SEC_PER_MIN_W;
          split_q  <= cts_pkg::SPLIT_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cts_pkg::REG_START_YEAR:   prdata = 32'(year_raw_q);
      cts_pkg::REG_START_MONTH:  prdata = 32'(month_raw_q);
      cts_pkg::REG_START_DAY:    prdata = 32'(day_raw_q);
      cts_pkg::REG_START_HOUR:   prdata = 32'(hour_raw_q);
      cts_pkg::REG_START_MINUTE: prdata = 32'(min_raw_q);
      cts_pkg::REG_START_SECOND: prdata = 32'(sec_raw_q);
      cts_pkg::REG_STEP_SECONDS: prdata = 32'(step_raw_q);
      cts_pkg::REG_SENSOR_COUNT: prdata = 32'(count_raw_q);
      default:                   prdata = 32'd0;
    endcase
  end

  // Saturated start time.
  always_comb begin
    if (month_raw_q == 4'd0)                   mon_c = cts_pkg::MONTH_FIRST;
    else if (month_raw_q > cts_pkg::MONTH_LAST) mon_c = cts_pkg::MONTH_LAST;
    else                                        mon_c = month_raw_q;
    dim = cts_pkg::days_in(mon_c, cts_pkg::is_leap(cent_q, yr_rem_q[6:0]));

    cfg_o.start.year  = year_clamp_q;
    cfg_o.start.cent  = cent_q;
    cfg_o.start.yy    = yr_rem_q[6:0];
    cfg_o.start.month = mon_c;
    if (day_raw_q == 5'd0)  cfg_o.start.day = cts_pkg::DAY_FIRST;
    else if (day_raw_q > dim) cfg_o.start.day = dim;
    else                      cfg_o.start.day = day_raw_q;
    cfg_o.start.hour   = (hour_raw_q > cts_pkg::HOUR_LAST) ? cts_pkg::HOUR_LAST : hour_raw_q;
    cfg_o.start.minute = (min_raw_q > cts_pkg::MINSEC_LAST) ? cts_pkg::MINSEC_LAST : min_raw_q;
    cfg_o.start.second = (sec_raw_q > cts_pkg::MINSEC_LAST) ? cts_pkg::MINSEC_LAST : sec_raw_q;
    cfg_o.step_h   = step_h_q;
    cfg_o.step_m   = step_m_q;
    cfg_o.step_s   = st_rem_q[5:0];
    cfg_o.sensor_n = count_clamp_q;
    cfg_o.busy     = busy;
  end

endmodule

`default_nettype wire

// ===== hdl/cts_time_core.sv =====
// Current date/time register and its next-value logic (load start or add step).
// Depends on cts_pkg.
`default_nettype none

module cts_time_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            advance_i,
  input  cts_pkg::cfg_t   cfg_i,
  output cts_pkg::stamp_t next_o
);

  cts_pkg::stamp_t cur_q, adv;

  logic [6:0] sec_sum, min_sum;
  logic [5:0] hr_sum;
  logic       c_sec, c_min, c_day;
  logic [4:0] dim;
  logic       day_wrap, mon_wrap, yy_wrap, overflow;

  always_comb begin
    sec_sum = 7'(cur_q.second) + 7'(cfg_i.step_s);
    c_sec   = (sec_sum >= cts_pkg::SEC_PER_MIN);
    min_sum = 7'(cur_q.minute) + 7'(cfg_i.step_m) + 7'(c_sec);
    c_min   = (min_sum >= cts_pkg::SEC_PER_MIN);
    hr_sum  = 6'(cur_q.hour) + 6'(cfg_i.step_h) + 6'(c_min);
    c_day   = (hr_sum >= cts_pkg::HOURS_PER_DAY);

    dim      = cts_pkg::days_in(cur_q.month, cts_pkg::is_leap(cur_q.cent, cur_q.yy));
    day_wrap = (cur_q.day >= dim);
    mon_wrap = (cur_q.month >= cts_pkg::MONTH_LAST);
    yy_wrap  = (cur_q.yy == cts_pkg::YY_LAST);
    overflow = c_day && day_wrap && mon_wrap && (cur_q.year == cts_pkg::YEAR_MAX);

    adv        = cur_q;
    adv.second = c_sec ? 6'(sec_sum - cts_pkg::SEC_PER_MIN) : sec_sum[5:0];
    adv.minute = c_min ? 6'(min_sum - cts_pkg::SEC_PER_MIN) : min_sum[5:0];
    adv.hour   = c_day ? 5'(hr_sum - cts_pkg::HOURS_PER_DAY) : hr_sum[4:0];
    if (c_day) begin
      if (!day_wrap) begin
        adv.day = cur_q.day + 5'd1;
      end else begin
        adv.day = cts_pkg::DAY_FIRST;
        if (!mon_wrap) begin
          adv.month = cur_q.month + 4'd1;
        end else begin
          adv.month = cts_pkg::MONTH_FIRST;
          adv.year  = cur_q.year + 14'd1;
          adv.yy    = yy_wrap ? 7'd0 : cur_q.yy + 7'd1;
          adv.cent  = yy_wrap ? cur_q.cent + 7'd1 : cur_q.cent;
        end
      end
    end
    // hold at 9999-12-31 23:59:59
    if (overflow) begin
      adv.year   = cts_pkg::YEAR_MAX;
      adv.cent   = cts_pkg::YY_LAST;
      adv.yy     = cts_pkg::YY_LAST;
      adv.month  = cts_pkg::MONTH_LAST;
      adv.day    = cts_pkg::DAYS_31;
      adv.hour   = cts_pkg::HOUR_LAST;
      adv.minute = cts_pkg::MINSEC_LAST;
      adv.second = cts_pkg::MINSEC_LAST;
    end

    next_o = advance_i ? adv : cfg_i.start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.year   <= cts_pkg::YEAR_MIN;
      cur_q.cent   <= cts_pkg::CENT_RESET;
      cur_q.yy     <= 7'd0;
      cur_q.month  <= cts_pkg::MONTH_FIRST;
      cur_q.day    <= cts_pkg::DAY_FIRST;
      cur_q.hour   <= 5'd0;
      cur_q.minute <= 6'd0;
      cur_q.second <= 6'd0;
    end else if (load_i) begin
      cur_q <= next_o;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cts_emitter.sv =====
// Result register: repeats one timestamp as sensor_count records, one per cycle while m_axis_tready is high.
// Depends on cts_pkg.
`default_nettype none

module cts_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  cts_pkg::stamp_t     stamp_i,
  input  logic [6:0]          count_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  output cts_pkg::emit_stat_t stat_o
);

  logic            valid_q, last_q;
  logic [6:0]      id_q, count_q;
  cts_pkg::stamp_t stamp_q;
  logic            xfer;

  assign xfer   = valid_q & m_axis_tready;
  assign free_o = !valid_q || (xfer && last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      id_q    <= 7'd0;
      count_q <= 7'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      id_q    <= 7'd1;
      count_q <= count_i;
      last_q  <= (count_i == 7'd1);
    end else if (xfer) begin
      if (last_q) begin
        valid_q <= 1'b0;
      end else begin
        id_q   <= id_q + 7'd1;
        last_q <= ((id_q + 7'd1) == count_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) stamp_q <= stamp_i;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {1'b0, stamp_q.second, stamp_q.minute, stamp_q.hour,
                          stamp_q.day, stamp_q.month, stamp_q.year, id_q};
  assign stat_o.sensor_id = id_q;
  assign stat_o.count     = count_q;

endmodule

`default_nettype wire
